// ----- design/trwl_pkg.sv -----
// ----------------------------------------------------------------------------
// trwl_pkg
// Shared types and constants for the timestamped pose ring with window lookup.
// ----------------------------------------------------------------------------
package trwl_pkg;

	// Field widths fixed by the transaction format
	localparam int TIME_W  = 47;
	localparam int RTIME_W = 48;
	localparam int POSE_W  = 32;

	// Longest row stream a single query may produce
	localparam int MAX_ROWS = 32;
	localparam int ROWS_W   = $clog2(MAX_ROWS + 1);

	// Reset value of the early start limit: 1.0 s in microseconds
	localparam logic [TIME_W-1:0] EARLY_LIMIT_RST = TIME_W'(1000000);

	// Result status codes
	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_ROW     = 3'd2;
	localparam logic [2:0] ST_NO_DATA = 3'd3;
	localparam logic [2:0] ST_MISSING = 3'd4;
	localparam logic [2:0] ST_BAD_WIN = 3'd5;

	// Input action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// One pose sample as stored in the ring
	typedef struct packed {
		logic signed [POSE_W-1:0] x;
		logic signed [POSE_W-1:0] y;
		logic signed [POSE_W-1:0] z;
		logic signed [POSE_W-1:0] roll;
		logic signed [POSE_W-1:0] pitch;
		logic signed [POSE_W-1:0] yaw;
	} pose_t;

endpackage

// ----- design/trwl_ring_mem.sv -----
// ----------------------------------------------------------------------------
// trwl_ring_mem
// Ring storage: timestamp and pose memories with one write and one read port,
// registered read data, and a per-slot valid bit that marks written slots.
// ----------------------------------------------------------------------------
module trwl_ring_mem import trwl_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     wr_addr,
	input  logic [TIME_W-1:0] wr_time,
	input  pose_t             wr_pose,
	input  logic              re,
	input  logic [AW-1:0]     rd_addr,
	output logic              rd_vld,
	output logic [TIME_W-1:0] rd_time,
	output pose_t             rd_pose,
	output logic [DEPTH-1:0]  vld
);

	logic [TIME_W-1:0] time_mem [DEPTH];
	pose_t             pose_mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic              rd_vld_q;
	logic [TIME_W-1:0] rd_time_q;
	pose_t             rd_pose_q;

	// Write and read the sample arrays; queries never overlap writes
	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[wr_addr] <= wr_time;
			pose_mem[wr_addr] <= wr_pose;
		end
		if (re) begin
			rd_time_q <= time_mem[rd_addr];
			rd_pose_q <= pose_mem[rd_addr];
		end
	end

	// Track written slots; an unwritten slot reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign vld     = vld_q;
	assign rd_vld  = rd_vld_q;
	assign rd_time = rd_time_q;
	assign rd_pose = rd_pose_q;

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		re |-> (int'(rd_addr) < DEPTH))
		else $error("ring read address beyond depth");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (int'(wr_addr) < DEPTH))
		else $error("ring write address beyond depth");

	a_wr_marks: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> vld_q[$past(wr_addr)])
		else $error("written slot not marked valid");

endmodule

// ----- design/timestamped_ring_window_lookup.sv -----
// ----------------------------------------------------------------------------
// timestamped_ring_window_lookup
// Ring of timestamped pose samples with binary-search time-window queries.
// ----------------------------------------------------------------------------
// A write transaction stores a sample at the write pointer (or reports full
// when it meets the read mark) and answers with one result through the
// output register. A query with an ordered window binary-searches the ring
// through the single read port of the sample memory: each search step reads
// then compares, a search takes at most ceil(log2(RING_DEPTH)) steps plus a
// closing state, and a query runs one or two searches with a check state after
// the first, then streams its rows (read, load output register per row) or
// answers with a status. Input is taken only while the block is idle, but a
// finished result may still wait in the output register meanwhile.
// Empty slots are tracked by valid flops, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module timestamped_ring_window_lookup import trwl_pkg::*; #(
	parameter int RING_DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [TIME_W-1:0]         cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [TIME_W-1:0]         sample_time,
	input  logic signed [POSE_W-1:0]  pos_x,
	input  logic signed [POSE_W-1:0]  pos_y,
	input  logic signed [POSE_W-1:0]  pos_z,
	input  logic signed [POSE_W-1:0]  roll,
	input  logic signed [POSE_W-1:0]  pitch,
	input  logic signed [POSE_W-1:0]  yaw,
	input  logic [TIME_W-1:0]         window_start,
	input  logic [TIME_W-1:0]         window_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                status,
	output logic signed [RTIME_W-1:0] row_time,
	output logic signed [POSE_W-1:0]  row_x,
	output logic signed [POSE_W-1:0]  row_y,
	output logic signed [POSE_W-1:0]  row_z,
	output logic signed [POSE_W-1:0]  row_roll,
	output logic signed [POSE_W-1:0]  row_pitch,
	output logic signed [POSE_W-1:0]  row_yaw,
	output logic                      last
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int SW = AW + 1;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic [SW-1:0] DEPTH_S  = SW'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_CHK,
		S_ROW_RD,
		S_ROW_CAP
	} state_t;

	// Fold a search index below twice the depth back into the ring
	function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] v);
		return (v >= DEPTH_S) ? AW'(v - DEPTH_S) : v[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] a);
		return (a == LAST_IDX) ? '0 : a + AW'(1);
	endfunction

	function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] a);
		return (a == '0) ? LAST_IDX : a - AW'(1);
	endfunction

	// Rows from first to end around the ring, capped at the stream limit
	function automatic logic [ROWS_W-1:0] row_count(input logic [AW-1:0] end_i,
			input logic [AW-1:0] first_i);
		logic [CW-1:0] e;
		logic [CW-1:0] f;
		logic [CW-1:0] c;
		e = CW'(end_i);
		f = CW'(first_i);
		if (end_i >= first_i) begin
			c = e - f + CW'(1);
		end else begin
			c = e + CW'(RING_DEPTH) - f + CW'(1);
		end
		if (int'(c) > MAX_ROWS) begin
			return ROWS_W'(MAX_ROWS);
		end
		return ROWS_W'(c);
	endfunction

	state_t              state_q;
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       rmark_q;
	logic [TIME_W-1:0]   limit_q;
	logic [TIME_W-1:0]   t1_q;
	logic [TIME_W-1:0]   t2_q;
	logic                phase_q;
	logic [SW-1:0]       left_q;
	logic [SW-1:0]       right_q;
	logic [SW-1:0]       mid_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       first_q;
	logic [AW-1:0]       slot_q;
	logic [ROWS_W-1:0]   rows_q;
	logic [2:0]          resp_q;

	logic                out_valid_q;
	logic [2:0]          status_q;
	logic [RTIME_W-1:0]  row_time_q;
	pose_t               row_pose_q;
	logic                last_q;

	logic                in_acc;
	logic                out_free;
	logic                out_load;
	logic                mem_we;
	pose_t               wr_pose;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                rd_vld;
	logic [TIME_W-1:0]   rd_time;
	pose_t               rd_pose;
	logic [RING_DEPTH-1:0] vld;

	logic [SW-1:0]       mid_c;
	logic [TIME_W-1:0]   tgt_c;
	logic                ge_c;
	logic [AW-1:0]       pos_c;
	logic [AW-1:0]       first0_c;
	logic [AW-1:0]       first_c;
	logic                none_at_t1_c;
	logic [SW-1:0]       right_init_c;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	// Output register takes a new result this cycle
	assign out_load = ((state_q == S_RESP) && out_free) || (state_q == S_ROW_CAP);

	// Store a sample unless the write pointer has met the read mark
	assign mem_we  = in_acc && (action == ACT_WRITE) && (wp_q != rmark_q);
	assign wr_pose = '{x: pos_x, y: pos_y, z: pos_z, roll: roll, pitch: pitch, yaw: yaw};

	trwl_ring_mem #(
		.DEPTH (RING_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (mem_we),
		.wr_addr (wp_q),
		.wr_time (sample_time),
		.wr_pose (wr_pose),
		.re      (rd_en),
		.rd_addr (rd_addr),
		.rd_vld  (rd_vld),
		.rd_time (rd_time),
		.rd_pose (rd_pose),
		.vld     (vld)
	);

	// Search step arithmetic and start slot selection
	always_comb begin
		mid_c        = SW'(({1'b0, left_q} + {1'b0, right_q}) >> 1);
		tgt_c        = phase_q ? t2_q : t1_q;
		ge_c         = rd_vld && (rd_time >= tgt_c);
		pos_c        = wrap_idx(left_q);
		first0_c     = prev_idx(pos_c);
		first_c      = ((t1_q <= limit_q) && !vld[first0_c]) ? pos_c : first0_c;
		// No sample at or after t1
		none_at_t1_c = !(rd_vld && (rd_time >= t1_q));
		right_init_c = SW'({1'b0, wp_q}) + DEPTH_S - SW'(1);
	end

	// Drive the memory read port
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot_q;
		case (state_q)
			S_SRCH_RD: begin
				if (left_q != right_q) begin
					rd_en   = 1'b1;
					rd_addr = wrap_idx(mid_c);
				end else if (!phase_q) begin
					rd_en   = 1'b1;
					rd_addr = pos_c;
				end
			end
			S_ROW_RD: begin
				rd_en   = out_free;
				rd_addr = slot_q;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = slot_q;
			end
		endcase
	end

	// Sequencer, ring pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rmark_q     <= LAST_IDX;
			limit_q     <= EARLY_LIMIT_RST;
			t1_q        <= '0;
			t2_q        <= '0;
			phase_q     <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			mid_q       <= '0;
			pos_q       <= '0;
			first_q     <= '0;
			slot_q      <= '0;
			rows_q      <= '0;
			resp_q      <= ST_STORED;
			out_valid_q <= 1'b0;
			status_q    <= ST_STORED;
			row_time_q  <= '0;
			row_pose_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end

			// Drop the output transaction once taken and nothing replaces it
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						t1_q <= window_start;
						t2_q <= window_end;
						if (action == ACT_WRITE) begin
							if (wp_q == rmark_q) begin
								resp_q <= ST_FULL;
							end else begin
								resp_q <= ST_STORED;
								wp_q   <= next_idx(wp_q);
							end
							state_q <= S_RESP;
						end else if (window_start > window_end) begin
							resp_q  <= ST_BAD_WIN;
							state_q <= S_RESP;
						end else begin
							phase_q <= 1'b0;
							left_q  <= SW'({1'b0, wp_q});
							right_q <= right_init_c;
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= resp_q;
						row_time_q  <= '0;
						row_pose_q  <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SRCH_RD: begin
					if (left_q != right_q) begin
						mid_q   <= mid_c;
						state_q <= S_SRCH_CMP;
					end else if (!phase_q) begin
						// Start search done: check the slot it landed on
						pos_q   <= pos_c;
						first_q <= first_c;
						state_q <= S_CHK;
					end else begin
						// End search done: stream from the start slot
						rmark_q <= first_q;
						slot_q  <= first_q;
						rows_q  <= row_count(pos_c, first_q);
						state_q <= S_ROW_RD;
					end
				end
				S_SRCH_CMP: begin
					// Halve the interval
					if (ge_c) begin
						right_q <= mid_q;
					end else begin
						left_q <= mid_q + SW'(1);
					end
					state_q <= S_SRCH_RD;
				end
				S_CHK: begin
					if (none_at_t1_c && !vld[first_q]) begin
						resp_q  <= ST_NO_DATA;
						state_q <= S_RESP;
					end else if (pos_q == wp_q) begin
						resp_q  <= ST_MISSING;
						state_q <= S_RESP;
					end else if (none_at_t1_c) begin
						rmark_q <= first_q;
						slot_q  <= first_q;
						rows_q  <= row_count(first_q, first_q);
						state_q <= S_ROW_RD;
					end else begin
						phase_q <= 1'b1;
						right_q <= right_init_c;
						state_q <= S_SRCH_RD;
					end
				end
				S_ROW_RD: begin
					if (out_free) begin
						state_q <= S_ROW_CAP;
					end
				end
				S_ROW_CAP: begin
					// Load one row; an empty slot reads as time -1, pose zero
					out_valid_q <= 1'b1;
					status_q    <= ST_ROW;
					row_time_q  <= rd_vld ? {1'b0, rd_time} : '1;
					row_pose_q  <= rd_vld ? rd_pose : '0;
					last_q      <= (rows_q == ROWS_W'(1));
					slot_q      <= next_idx(slot_q);
					rows_q      <= rows_q - ROWS_W'(1);
					state_q     <= (rows_q == ROWS_W'(1)) ? S_IDLE : S_ROW_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign row_time  = row_time_q;
	assign row_x     = row_pose_q.x;
	assign row_y     = row_pose_q.y;
	assign row_z     = row_pose_q.z;
	assign row_roll  = row_pose_q.roll;
	assign row_pitch = row_pose_q.pitch;
	assign row_yaw   = row_pose_q.yaw;
	assign last      = last_q;

	a_row_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW_CAP) |-> !out_valid_q)
		else $error("row load while output register still occupied");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (wp_q != rmark_q))
		else $error("write at the read mark");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH_RD || state_q == S_SRCH_CMP) |-> (left_q <= right_q))
		else $error("search interval inverted");

	a_last_row_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW_CAP && rows_q == ROWS_W'(1)) |=> (state_q == S_IDLE && last_q))
		else $error("row stream did not end on its last row");

endmodule
